/* hdl/rfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_pkg: shared types and helpers for the record field decoder
// Field kind and status codes, the classified item that travels from the
// front to the back, and the CRC-32C and hex digit helpers.
// ---------------------------------------------------------------------------
package rfd_pkg;

	// field kinds
	localparam logic [1:0] MODE_VARINT  = 2'd0;
	localparam logic [1:0] MODE_DECIMAL = 2'd1;
	localparam logic [1:0] MODE_HEX     = 2'd2;
	localparam logic [1:0] MODE_WORD    = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_CHAR = 2'd1;
	localparam logic [1:0] ST_END      = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	localparam int unsigned VALUE_W   = 64;
	localparam int unsigned CRC_W     = 32;
	localparam int unsigned SHIFT_W   = 7;
	localparam int unsigned GROUP_W   = 7;
	localparam logic [SHIFT_W-1:0] VARINT_STEP  = 7'd7;
	localparam logic [SHIFT_W-1:0] VARINT_LIMIT = 7'd70;
	localparam logic [SHIFT_W-1:0] VALUE_BITS   = 7'd64;
	localparam logic [CRC_W-1:0]   CRC_POLY     = 32'h82f6_3b78;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// classified input item
	typedef struct packed {
		logic [7:0] data;
		logic [1:0] mode;
		logic       eod;
		logic       clr;
		logic       is_digit;
		logic       hex_bad;
		logic [3:0] hex_val;
	} rfd_item_t;

	// queue status toward its users
	typedef struct packed {
		logic full;
		logic head_valid;
	} rfd_qstat_t;

	// one byte of reflected CRC-32C
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// hex digit decode: bit 4 set for a non-hex character
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d = {1'b0, c[3:0] + 4'd9};
		end else begin
			d = 5'h10;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

/* hdl/rfd_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_in_if / rfd_out_if: byte and field channels
// Valid/ready channels carrying stream bytes in and decoded fields out.
// ---------------------------------------------------------------------------
interface rfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] mode;
	logic       end_of_data;
	logic       clear_crc;

	modport source (output valid, data_byte, mode, end_of_data, clear_crc, input ready);
	modport sink   (input valid, data_byte, mode, end_of_data, clear_crc, output ready);
endinterface

interface rfd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;
	logic        byte_used;
	logic [31:0] checksum;

	modport source (output valid, value, status, byte_used, checksum, input ready);
	modport sink   (input valid, value, status, byte_used, checksum, output ready);
endinterface
`default_nettype wire

/* hdl/rfd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_queue: short queue between front and back
// Small register FIFO of classified items; push and pop may share a cycle.
// ---------------------------------------------------------------------------
module rfd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rfd_pkg::rfd_item_t push_item,
	input  wire logic              pop,
	output rfd_pkg::rfd_qstat_t    stat,
	output rfd_pkg::rfd_item_t     head_item
);

	rfd_pkg::rfd_item_t                   entry_q [rfd_pkg::QUEUE_DEPTH];
	logic [rfd_pkg::QPTR_W-1:0]           wr_ptr_q;
	logic [rfd_pkg::QPTR_W-1:0]           rd_ptr_q;
	logic [rfd_pkg::QCNT_W-1:0]           count_q;

	localparam logic [rfd_pkg::QPTR_W-1:0] LAST_PTR =
		rfd_pkg::QPTR_W'(rfd_pkg::QUEUE_DEPTH - 1);

	assign stat.full       = (count_q == rfd_pkg::QCNT_W'(rfd_pkg::QUEUE_DEPTH));
	assign stat.head_valid = (count_q != '0);
	assign head_item       = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

/* hdl/rfd_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_front: byte intake and classification
// Takes stream bytes, tags digit and hex classes and pushes them queued.
// ---------------------------------------------------------------------------
module rfd_front (
	rfd_in_if.sink                 byte_ch,
	input  wire rfd_pkg::rfd_qstat_t qstat,
	output logic                   push,
	output rfd_pkg::rfd_item_t     push_item
);

	logic [4:0] hex_dec;

	// take a byte whenever the queue has room
	assign byte_ch.ready = !qstat.full;
	assign push          = byte_ch.valid && !qstat.full;

	// character classes
	assign hex_dec = rfd_pkg::hex_digit(byte_ch.data_byte);

	always_comb begin
		push_item.data     = byte_ch.data_byte;
		push_item.mode     = byte_ch.mode;
		push_item.eod      = byte_ch.end_of_data;
		push_item.clr      = byte_ch.clear_crc;
		push_item.is_digit = (byte_ch.data_byte >= 8'h30) && (byte_ch.data_byte <= 8'h39);
		push_item.hex_bad  = hex_dec[4];
		push_item.hex_val  = hex_dec[3:0];
	end

endmodule
`default_nettype wire

/* hdl/rfd_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_back: field state, checksum and result register
// Applies one classified byte per cycle to the field state and the CRC; a
// field-ending byte waits for the output register of finished fields to free.
// ---------------------------------------------------------------------------
module rfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rfd_pkg::rfd_qstat_t qstat,
	input  wire rfd_pkg::rfd_item_t  head_item,
	output logic                   pop,
	rfd_out_if.source              field_ch
);

	// field state
	logic [63:0] acc_q;
	logic [6:0]  shift_q;
	logic        active_q;
	logic [3:0]  nibble_q;
	logic [1:0]  wcnt_q;
	logic [31:0] crc_q;

	// result register
	logic        out_valid_q;
	logic [63:0] out_value_q;
	logic [1:0]  out_status_q;
	logic        out_used_q;
	logic [31:0] out_crc_q;

	// next state
	logic [63:0] acc_d;
	logic [6:0]  shift_d;
	logic        active_d;
	logic [3:0]  nibble_d;
	logic [1:0]  wcnt_d;
	logic [31:0] crc_base;
	logic [31:0] crc_d;
	logic        done;
	logic        used;
	logic [63:0] val;
	logic [1:0]  st;
	logic [63:0] group_sh;
	logic [63:0] times_ten;
	logic [63:0] word_sh;

	assign crc_base  = head_item.clr ? '0 : crc_q;
	assign group_sh  = (shift_q < rfd_pkg::VALUE_BITS)
		? ({57'd0, head_item.data[rfd_pkg::GROUP_W-1:0]} << shift_q[5:0]) : '0;
	assign times_ten = (acc_q << 3) + (acc_q << 1) + {60'd0, head_item.data[3:0]};
	assign word_sh   = {56'd0, head_item.data} << {wcnt_q, 3'b000};

	// per-kind field update
	always_comb begin
		acc_d    = acc_q;
		shift_d  = shift_q;
		active_d = active_q;
		nibble_d = nibble_q;
		wcnt_d   = wcnt_q;
		done     = 1'b0;
		used     = 1'b1;
		val      = '0;
		st       = rfd_pkg::ST_OK;
		if (head_item.eod) begin
			used = 1'b0;
			done = 1'b1;
			if (head_item.mode == rfd_pkg::MODE_DECIMAL && active_q) begin
				val = acc_q;
			end else begin
				st = rfd_pkg::ST_END;
			end
		end else begin
			unique case (head_item.mode)
				rfd_pkg::MODE_VARINT: begin
					if (shift_q >= rfd_pkg::VARINT_LIMIT) begin
						st   = rfd_pkg::ST_OVERFLOW;
						done = 1'b1;
					end else begin
						acc_d = acc_q | group_sh;
						if (head_item.data[7]) begin
							val  = acc_d;
							done = 1'b1;
						end else begin
							shift_d  = shift_q + rfd_pkg::VARINT_STEP;
							active_d = 1'b1;
						end
					end
				end
				rfd_pkg::MODE_DECIMAL: begin
					if (!active_q) begin
						if (head_item.is_digit) begin
							acc_d    = {60'd0, head_item.data[3:0]};
							active_d = 1'b1;
						end else begin
							st   = rfd_pkg::ST_BAD_CHAR;
							done = 1'b1;
						end
					end else if (head_item.is_digit) begin
						acc_d = times_ten;
					end else begin
						val  = acc_q;
						used = 1'b0;
						done = 1'b1;
					end
				end
				rfd_pkg::MODE_HEX: begin
					if (!active_q) begin
						nibble_d = head_item.hex_val;
						acc_d    = {63'd0, head_item.hex_bad};
						active_d = 1'b1;
					end else begin
						if (head_item.hex_bad || acc_q[0]) begin
							st = rfd_pkg::ST_BAD_CHAR;
						end else begin
							val = {56'd0, nibble_q, head_item.hex_val};
						end
						done = 1'b1;
					end
				end
				rfd_pkg::MODE_WORD: begin
					acc_d = acc_q | word_sh;
					if (wcnt_q == 2'd3) begin
						val  = {32'd0, acc_d[31:0]};
						done = 1'b1;
					end else begin
						wcnt_d   = wcnt_q + 2'd1;
						active_d = 1'b1;
					end
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end
		crc_d = (used && !head_item.eod) ? rfd_pkg::crc_byte(crc_base, head_item.data)
			: crc_base;
	end

	// a field-ending byte needs a free result slot
	assign pop = qstat.head_valid && (!done || !out_valid_q || field_ch.ready);

	// field state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			shift_q  <= '0;
			active_q <= 1'b0;
			nibble_q <= '0;
			wcnt_q   <= '0;
			crc_q    <= '0;
		end else if (pop) begin
			crc_q <= crc_d;
			if (done) begin
				acc_q    <= '0;
				shift_q  <= '0;
				active_q <= 1'b0;
				nibble_q <= '0;
				wcnt_q   <= '0;
			end else begin
				acc_q    <= acc_d;
				shift_q  <= shift_d;
				active_q <= active_d;
				nibble_q <= nibble_d;
				wcnt_q   <= wcnt_d;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && done) begin
			out_valid_q <= 1'b1;
		end else if (field_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && done) begin
			out_value_q  <= (st != rfd_pkg::ST_OK) ? '0 : val;
			out_status_q <= st;
			out_used_q   <= used;
			out_crc_q    <= crc_d;
		end
	end

	assign field_ch.valid     = out_valid_q;
	assign field_ch.value     = out_value_q;
	assign field_ch.status    = out_status_q;
	assign field_ch.byte_used = out_used_q;
	assign field_ch.checksum  = out_crc_q;

endmodule
`default_nettype wire

/* hdl/record_field_decoder_crc32c_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// record_field_decoder_crc32c_core: record field decoder with CRC-32C
// Decodes varint, decimal, hex pair and little-endian word fields from a
// byte stream and keeps a running CRC-32C over the consumed bytes.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle while its queue has room; the byte
// that ends a field is registered in the queue, then its result is registered
// in the back stage and offered. With the result side ready it sustains one
// byte every cycle. The back stage sets that figure: each byte is applied
// combinationally through the CRC-32C byte step and the 64-bit times-ten
// add of the decimal field. A two-entry queue between intake and back lets
// the byte side keep going for two bytes while a finished field waits to
// be taken; bytes that end no field pass through even while a result waits.
module record_field_decoder_crc32c_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	rfd_in_if.sink     byte_ch,
	rfd_out_if.source  field_ch
);

	logic                 push;
	logic                 pop;
	rfd_pkg::rfd_item_t   push_item;
	rfd_pkg::rfd_item_t   head_item;
	rfd_pkg::rfd_qstat_t  qstat;

	// intake and classification
	rfd_front u_front (
		.byte_ch   (byte_ch),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	rfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.stat      (qstat),
		.head_item (head_item)
	);

	// field decode and checksum
	rfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head_item (head_item),
		.pop       (pop),
		.field_ch  (field_ch)
	);

endmodule
`default_nettype wire

/* hdl/rfd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rfd_checker: port-level checks for the record field decoder
// Watches the result channel for hold behavior and status consistency.
// ---------------------------------------------------------------------------
module rfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] out_value,
	input wire logic [1:0]  out_status,
	input wire logic        out_byte_used,
	input wire logic [31:0] out_checksum
);

	// a stalled result stays offered
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_status)
			&& $stable(out_byte_used) && $stable(out_checksum))
		else $error("result payload changed while stalled");

	// an error result carries a zero value
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != rfd_pkg::ST_OK |-> out_value == '0)
		else $error("error result with nonzero value");

	// bad character and overflow always consume the byte
	a_error_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == rfd_pkg::ST_BAD_CHAR || out_status == rfd_pkg::ST_OVERFLOW)
			|-> out_byte_used)
		else $error("bad character or overflow did not consume the byte");

endmodule

bind record_field_decoder_crc32c_core rfd_checker u_rfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (field_ch.valid),
	.out_ready     (field_ch.ready),
	.out_value     (field_ch.value),
	.out_status    (field_ch.status),
	.out_byte_used (field_ch.byte_used),
	.out_checksum  (field_ch.checksum)
);
`default_nettype wire

/* bench/tb_record_field_decoder_crc32c_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_record_field_decoder_crc32c_core: self-checking bench for the field decoder
// Sends a byte stream of varint, decimal, hex pair and little-endian word
// fields through the core. A directed table with hand-written results comes
// first, then about two thousand random bytes, mostly whole fields.
// Other decoded fields are checked against a local model of the decoder.
// Both handshake sides stall at random, and one long result-side hold
// fills the core and backs up its byte input.
// ---------------------------------------------------------------------------
module tb_record_field_decoder_crc32c_core;

	localparam int          RANDOM_ITEMS = 2000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          DRAIN_CYCLES = 32;
	localparam int          PRINT_LIMIT  = 40;
	localparam longint      RUN_LIMIT_NS = 64'd5_000_000;
	localparam logic [31:0] CRC32C_POLY  = 32'h82f6_3b78;

	// one decoded field as it leaves the core
	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  status;
		logic        used;
		logic [31:0] checksum;
	} field_t;

	// one stream byte, with an optional hand-written result
	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  mode;
		logic        eod;
		logic        clr;
		logic        typed;
		logic        crc_typed;
		logic [63:0] value;
		logic [1:0]  status;
		logic        used;
		logic [31:0] checksum;
	} stream_item_t;

	// data, mode, eod, clr, typed, crc_typed, value, status, used, checksum
	localparam stream_item_t DIRECTED_ROWS [0:27] = '{
		// end of data with no field open, right after reset
		'{8'h00, rfd_pkg::MODE_VARINT, 1'b1, 1'b0, 1'b1, 1'b1,
			64'd0, rfd_pkg::ST_END, 1'b0, 32'd0},
		// decimal starting with a NUL, checksum cleared first
		'{8'h00, rfd_pkg::MODE_DECIMAL, 1'b0, 1'b1, 1'b1, 1'b1,
			64'd0, rfd_pkg::ST_BAD_CHAR, 1'b1, 32'd0},
		// ten non-final varint groups, then one byte too many
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h7F, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'hFF, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b1, 1'b0,
			64'd0, rfd_pkg::ST_OVERFLOW, 1'b1, 32'd0},
		// decimal "9" ended by '/', which comes back unused
		'{8'h39, rfd_pkg::MODE_DECIMAL, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h2F, rfd_pkg::MODE_DECIMAL, 1'b0, 1'b0, 1'b1, 1'b0,
			64'd9, rfd_pkg::ST_OK, 1'b0, 32'd0},
		// the returned '/' offered again cannot start a decimal
		'{8'h2F, rfd_pkg::MODE_DECIMAL, 1'b0, 1'b0, 1'b1, 1'b0,
			64'd0, rfd_pkg::ST_BAD_CHAR, 1'b1, 32'd0},
		// decimal "5" ended by end of data still gives its value
		'{8'h35, rfd_pkg::MODE_DECIMAL, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'hA5, rfd_pkg::MODE_DECIMAL, 1'b1, 1'b0, 1'b1, 1'b0,
			64'd5, rfd_pkg::ST_OK, 1'b0, 32'd0},
		// hex "fF"
		'{8'h66, rfd_pkg::MODE_HEX, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h46, rfd_pkg::MODE_HEX, 1'b0, 1'b0, 1'b1, 1'b0,
			64'hFF, rfd_pkg::ST_OK, 1'b1, 32'd0},
		// hex "g0": bad first digit, flagged after the second
		'{8'h67, rfd_pkg::MODE_HEX, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h30, rfd_pkg::MODE_HEX, 1'b0, 1'b0, 1'b1, 1'b0,
			64'd0, rfd_pkg::ST_BAD_CHAR, 1'b1, 32'd0},
		// all-ones little-endian word
		'{8'hFF, rfd_pkg::MODE_WORD, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'hFF, rfd_pkg::MODE_WORD, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'hFF, rfd_pkg::MODE_WORD, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'hFF, rfd_pkg::MODE_WORD, 1'b0, 1'b0, 1'b1, 1'b0,
			64'hFFFF_FFFF, rfd_pkg::ST_OK, 1'b1, 32'd0},
		// end of data inside a varint
		'{8'h01, rfd_pkg::MODE_VARINT, 1'b0, 1'b0, 1'b0, 1'b0,
			64'd0, rfd_pkg::ST_OK, 1'b0, 32'd0},
		'{8'h00, rfd_pkg::MODE_HEX, 1'b1, 1'b0, 1'b1, 1'b0,
			64'd0, rfd_pkg::ST_END, 1'b0, 32'd0}
	};

	logic clk;
	logic arst_n;

	rfd_in_if  byte_ch ();
	rfd_out_if field_ch ();

	record_field_decoder_crc32c_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.field_ch (field_ch)
	);

	stream_item_t byte_stream[$];
	field_t       pending_fields[$];
	int           bytes_taken = 0;
	int           mismatches  = 0;
	bit           stim_done   = 1'b0;
	bit           sink_hold   = 1'b0;
	string        hex_set     = "0123456789abcdefABCDEF";

	// decoder model state
	logic [63:0] acc;
	logic [6:0]  shamt;
	logic        in_field;
	logic [3:0]  nib;
	logic [1:0]  wcnt;
	logic [31:0] crc_run;

	// clock and reset
	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// reflected crc-32c, one bit of the byte at a time
	function automatic logic [31:0] crc32c_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int k = 0; k < 8; k++) begin
			fb = c[0] ^ b[k];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC32C_POLY;
			end
		end
		return c;
	endfunction

	// hex character value, bit 4 marks a non-hex character
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b0, 4'(c - 8'h30)};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			return {1'b0, 4'(c - 8'h57)};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			return {1'b0, 4'(c - 8'h37)};
		end
		return 5'h10;
	endfunction

	// advance the model by one byte; returns 1 when a field ends
	function automatic bit decode_byte(input stream_item_t it, output field_t res);
		bit          done;
		bit          used;
		logic [63:0] val;
		logic [1:0]  st;
		logic [4:0]  d;
		bit          digit;
		done  = 1'b0;
		used  = 1'b1;
		val   = 64'd0;
		st    = rfd_pkg::ST_OK;
		digit = (it.data >= 8'h30 && it.data <= 8'h39);
		res   = '0;
		if (it.clr) begin
			crc_run = 32'd0;
		end
		if (it.eod) begin
			used = 1'b0;
			done = 1'b1;
			if (it.mode == rfd_pkg::MODE_DECIMAL && in_field) begin
				val = acc;
			end else begin
				st = rfd_pkg::ST_END;
			end
		end else begin
			unique case (it.mode)
			rfd_pkg::MODE_VARINT: begin
				if (shamt >= 7'd70) begin
					st   = rfd_pkg::ST_OVERFLOW;
					done = 1'b1;
				end else begin
					// groups past bit 63 fall off the top
					if (shamt < 7'd64) begin
						acc = acc | ({57'd0, it.data[6:0]} << shamt);
					end
					if (it.data[7]) begin
						val  = acc;
						done = 1'b1;
					end else begin
						shamt    = shamt + 7'd7;
						in_field = 1'b1;
					end
				end
			end
			rfd_pkg::MODE_DECIMAL: begin
				if (!in_field) begin
					if (digit) begin
						acc      = {60'd0, 4'(it.data - 8'h30)};
						in_field = 1'b1;
					end else begin
						st   = rfd_pkg::ST_BAD_CHAR;
						done = 1'b1;
					end
				end else if (digit) begin
					acc = acc * 64'd10 + {60'd0, 4'(it.data - 8'h30)};
				end else begin
					// terminator goes back unused
					val  = acc;
					used = 1'b0;
					done = 1'b1;
				end
			end
			rfd_pkg::MODE_HEX: begin
				d = hex_nibble(it.data);
				if (!in_field) begin
					nib      = d[3:0];
					acc      = {63'd0, d[4]};
					in_field = 1'b1;
				end else begin
					if (d[4] || acc[0]) begin
						st = rfd_pkg::ST_BAD_CHAR;
					end else begin
						val = {56'd0, nib, d[3:0]};
					end
					done = 1'b1;
				end
			end
			default: begin
				acc = acc | ({56'd0, it.data} << (8 * int'(wcnt)));
				if (wcnt == 2'd3) begin
					val  = {32'd0, acc[31:0]};
					done = 1'b1;
				end else begin
					wcnt     = wcnt + 2'd1;
					in_field = 1'b1;
				end
			end
			endcase
		end
		if (used && !it.eod) begin
			crc_run = crc32c_step(crc_run, it.data);
		end
		if (done) begin
			acc      = 64'd0;
			shamt    = 7'd0;
			in_field = 1'b0;
			nib      = 4'd0;
			wcnt     = 2'd0;
			res.value    = (st != rfd_pkg::ST_OK) ? 64'd0 : val;
			res.status   = st;
			res.used     = used;
			res.checksum = crc_run;
		end
		return done;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < PRINT_LIMIT) begin
			$display("%0t: mismatch in %s: got %h, want %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic logic [7:0] non_digit();
		logic [7:0] b;
		do begin
			b = 8'($urandom);
		end while (b >= 8'h30 && b <= 8'h39);
		return b;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic [1:0] md, input logic eod);
		stream_item_t it;
		it      = '0;
		it.data = b;
		it.mode = md;
		it.eod  = eod;
		it.clr  = ($urandom_range(0, 31) == 0);
		byte_stream.push_back(it);
	endtask

	// directed rows, then random fields, mostly well formed
	task automatic build_stream();
		int         kind;
		int         n;
		logic [1:0] m;
		logic [7:0] b;
		foreach (DIRECTED_ROWS[r]) begin
			byte_stream.push_back(DIRECTED_ROWS[r]);
		end
		while (byte_stream.size() < $size(DIRECTED_ROWS) + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			unique case (kind)
			0, 1: begin
				if ($urandom_range(0, 9) == 0) begin
					// run past ten groups
					repeat (10) push_byte({1'b0, 7'($urandom)}, rfd_pkg::MODE_VARINT, 1'b0);
					push_byte(8'($urandom), rfd_pkg::MODE_VARINT, 1'b0);
				end else if ($urandom_range(0, 15) == 0) begin
					// widest value, bit 63 from the tenth byte
					repeat (9) push_byte(8'h7F, rfd_pkg::MODE_VARINT, 1'b0);
					push_byte(8'h81, rfd_pkg::MODE_VARINT, 1'b0);
				end else begin
					n = $urandom_range(1, 10);
					repeat (n - 1) push_byte({1'b0, 7'($urandom)}, rfd_pkg::MODE_VARINT, 1'b0);
					push_byte({1'b1, 7'($urandom)}, rfd_pkg::MODE_VARINT, 1'b0);
				end
			end
			2, 3: begin
				if ($urandom_range(0, 9) == 0) begin
					push_byte(non_digit(), rfd_pkg::MODE_DECIMAL, 1'b0);
				end else begin
					// long runs wrap past 2^64
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(18, 26)
						: $urandom_range(1, 6);
					repeat (n) push_byte(8'h30 + 8'($urandom_range(0, 9)),
						rfd_pkg::MODE_DECIMAL, 1'b0);
					if ($urandom_range(0, 5) == 0) begin
						push_byte(8'($urandom), rfd_pkg::MODE_DECIMAL, 1'b1);
					end else begin
						push_byte(non_digit(), rfd_pkg::MODE_DECIMAL, 1'b0);
					end
				end
			end
			4, 5: repeat (2) begin
				if ($urandom_range(0, 7) == 0) begin
					b = 8'($urandom);
				end else begin
					b = hex_set[$urandom_range(0, 21)];
				end
				push_byte(b, rfd_pkg::MODE_HEX, 1'b0);
			end
			6, 7: repeat (4) push_byte(8'($urandom), rfd_pkg::MODE_WORD, 1'b0);
			8: begin
				// field cut short by end of data
				m = 2'($urandom);
				n = $urandom_range(1, 3);
				repeat (n) begin
					b = 8'($urandom);
					if (m == rfd_pkg::MODE_VARINT) begin
						b[7] = 1'b0;
					end
					push_byte(b, m, 1'b0);
				end
				push_byte(8'($urandom), 2'($urandom), 1'b1);
			end
			default: begin
				// noise, kinds switch freely
				n = $urandom_range(1, 4);
				repeat (n) push_byte(8'($urandom), 2'($urandom), $urandom_range(0, 3) == 0);
			end
			endcase
		end
	endtask

	// byte side driver
	initial begin : byte_source
		int gap;
		bit src_idle_on;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = 8'h00;
		byte_ch.mode        = rfd_pkg::MODE_VARINT;
		byte_ch.end_of_data = 1'b0;
		byte_ch.clear_crc   = 1'b0;
		src_idle_on = 1'b1;
		build_stream();
		wait (arst_n === 1'b1);
		@(negedge clk);
		for (int i = 0; i < byte_stream.size(); i++) begin
			if (i % 128 == 0) begin
				src_idle_on = ($urandom_range(0, 2) != 0);
			end
			gap = src_idle_on ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			byte_ch.valid       <= 1'b1;
			byte_ch.data_byte   <= byte_stream[i].data;
			byte_ch.mode        <= byte_stream[i].mode;
			byte_ch.end_of_data <= byte_stream[i].eod;
			byte_ch.clear_crc   <= byte_stream[i].clr;
			do begin
				@(posedge clk);
			end while (byte_ch.ready !== 1'b1);
			@(negedge clk);
		end
		byte_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// field side ready, with random stalls per result
	initial begin : field_sink
		int stall;
		int taken;
		bit snk_idle_on;
		field_ch.ready = 1'b0;
		stall       = 0;
		taken       = 0;
		snk_idle_on = 1'b1;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (field_ch.valid === 1'b1 && field_ch.ready === 1'b1) begin
				taken++;
				if (taken % 100 == 0) begin
					snk_idle_on = ($urandom_range(0, 2) != 0);
				end
				stall = snk_idle_on ? $urandom_range(0, 12) : 0;
			end
			@(negedge clk);
			field_ch.ready <= (!sink_hold && stall == 0);
			if (!sink_hold && stall > 0) begin
				stall--;
			end
		end
	end

	// one long hold on the field side while bytes keep coming
	initial begin : long_hold
		wait (bytes_taken >= 600);
		@(posedge clk);
		sink_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold = 1'b0;
	end

	// model on byte transfers, compare on field transfers
	always @(posedge clk or negedge arst_n) begin : field_check
		stream_item_t it;
		field_t       pred;
		field_t       want;
		if (!arst_n) begin
			acc      = 64'd0;
			shamt    = 7'd0;
			in_field = 1'b0;
			nib      = 4'd0;
			wcnt     = 2'd0;
			crc_run  = 32'd0;
		end else begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
				it = byte_stream[bytes_taken];
				if (decode_byte(it, pred)) begin
					if (it.typed) begin
						want.value    = it.value;
						want.status   = it.status;
						want.used     = it.used;
						want.checksum = it.crc_typed ? it.checksum : pred.checksum;
						pending_fields.push_back(want);
					end else begin
						pending_fields.push_back(pred);
					end
				end
				bytes_taken++;
			end
			if (field_ch.valid === 1'b1 && field_ch.ready === 1'b1) begin
				if (pending_fields.size() == 0) begin
					report_mismatch("unexpected result", field_ch.value, 64'd0);
				end else begin
					want = pending_fields.pop_front();
					if (field_ch.value !== want.value) begin
						report_mismatch("value", field_ch.value, want.value);
					end
					if (field_ch.status !== want.status) begin
						report_mismatch("status", 64'(field_ch.status), 64'(want.status));
					end
					if (field_ch.byte_used !== want.used) begin
						report_mismatch("byte_used", 64'(field_ch.byte_used), 64'(want.used));
					end
					if (field_ch.checksum !== want.checksum) begin
						report_mismatch("checksum", 64'(field_ch.checksum), 64'(want.checksum));
					end
				end
			end
		end
	end

	// end of run
	initial begin : run_end
		wait (stim_done);
		while (pending_fields.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// hard stop if the core hangs
	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("timeout: %0d bytes taken, %0d results outstanding", bytes_taken,
			pending_fields.size());
		$display("Verification failed");
		$finish;
	end

endmodule
